// File: sv/sbi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbi_pkg
// Shared types and codes for the switchgear bay interlock controller.
// ----------------------------------------------------------------------------

package sbi_pkg;

    localparam int FUNC_W   = 3;
    localparam int TARGET_W = 3;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_OPERATE   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_TRIP_SET  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_TRIP_CLR  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_CPLR_SET  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CPLR_CLR  = 3'd4;

    localparam logic [TARGET_W-1:0] TGT_BREAKER = 3'd0;
    localparam logic [TARGET_W-1:0] TGT_BUS_A   = 3'd1;
    localparam logic [TARGET_W-1:0] TGT_BUS_B   = 3'd2;
    localparam logic [TARGET_W-1:0] TGT_LINE    = 3'd3;
    localparam logic [TARGET_W-1:0] TGT_EARTH   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BLOCKED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TEST    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_BAY_IS_COUPLER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_DS_FITTED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EARTH_FITTED   = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [TARGET_W-1:0] target;
        logic                close_request;
        logic                test_request;
    } in_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                breaker_closed;
        logic                bus_a_closed;
        logic                bus_b_closed;
        logic                line_ds_closed;
        logic                earth_closed;
        logic                coupling_closed;
        logic                lockout_active;
    } out_word_t;

    typedef struct packed {
        logic breaker_pos;
        logic bus_a_pos;
        logic bus_b_pos;
        logic line_ds_pos;
        logic earth_pos;
        logic trip_lockout;
        logic cplr_rdy;
    } bay_state_t;

    localparam bay_state_t BAY_STATE_RESET = '{
        breaker_pos:   1'b1,
        bus_a_pos:     1'b1,
        bus_b_pos:     1'b0,
        line_ds_pos:   1'b1,
        earth_pos:     1'b0,
        trip_lockout:  1'b0,
        cplr_rdy:      1'b0
    };

endpackage

// File: sv/switchgear_bay_interlock.sv
`timescale 1ns / 1ps
// A word from s_ enters the input register, then the result register on m_.
// Throughput: one word per cycle while m_ready is high; the input register and
// result register let a new word enter while a finished result waits on m_.
// Reset (aresetn low, synchronous): switch positions, lockout, coupler-ready
// and configuration take their reset values and both registers empty.
// ----------------------------------------------------------------------------
// switchgear_bay_interlock
// Interlocking controller for one bay: checks open and close commands against
// the interlock rules, handles trip and coupler-ready commands, and reports
// the outcome together with all switch positions.
// ----------------------------------------------------------------------------

module switchgear_bay_interlock (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  sbi_pkg::in_word_t                s_word,
    output logic                             m_valid,
    input  logic                             m_ready,
    output sbi_pkg::out_word_t               m_word,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sbi_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic                             cfg_data
);

    logic                 in_vld_reg;
    sbi_pkg::in_word_t    in_word_reg;
    logic                 out_vld_reg;
    sbi_pkg::out_word_t   out_word_reg;
    sbi_pkg::bay_state_t  state_reg;
    sbi_pkg::bay_state_t  state_next;
    logic [sbi_pkg::STATUS_W-1:0] status_next;
    sbi_pkg::out_word_t   result_next;
    logic                 bay_is_coupler_reg;
    logic                 line_fitted_reg;
    logic                 earth_fitted_reg;
    logic                 advance;

    assign advance   = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready   = !in_vld_reg || advance;
    assign m_valid   = out_vld_reg;
    assign m_word    = out_word_reg;
    assign cfg_ready = 1'b1;

    always_comb begin
        logic bypass;
        logic earthed;
        logic other_bus;
        logic cl;
        bypass      = state_reg.cplr_rdy || bay_is_coupler_reg;
        earthed     = earth_fitted_reg && state_reg.earth_pos;
        cl          = in_word_reg.close_request;
        other_bus   = (in_word_reg.target == sbi_pkg::TGT_BUS_A) ?
                      state_reg.bus_b_pos : state_reg.bus_a_pos;
        state_next  = state_reg;
        status_next = sbi_pkg::ST_DONE;
        unique case (in_word_reg.func)
            sbi_pkg::FUNC_OPERATE: begin
                if (in_word_reg.test_request) begin
                    status_next = sbi_pkg::ST_TEST;
                end else begin
                    unique case (in_word_reg.target) inside
                        sbi_pkg::TGT_BREAKER: begin
                            if (cl && (state_reg.earth_pos || state_reg.trip_lockout)) begin
                                status_next = sbi_pkg::ST_BLOCKED;
                            end else begin
                                state_next.breaker_pos = cl;
                            end
                        end
                        sbi_pkg::TGT_BUS_A, sbi_pkg::TGT_BUS_B: begin
                            if ((state_reg.breaker_pos && !bypass) ||
                                (cl && other_bus && !bypass) || (cl && earthed)) begin
                                status_next = sbi_pkg::ST_BLOCKED;
                            end else if (in_word_reg.target == sbi_pkg::TGT_BUS_A) begin
                                state_next.bus_a_pos = cl;
                            end else begin
                                state_next.bus_b_pos = cl;
                            end
                        end
                        sbi_pkg::TGT_LINE: begin
                            if (!line_fitted_reg) begin
                                status_next = sbi_pkg::ST_ABSENT;
                            end else if (state_reg.breaker_pos || (cl && earthed)) begin
                                status_next = sbi_pkg::ST_BLOCKED;
                            end else begin
                                state_next.line_ds_pos = cl;
                            end
                        end
                        sbi_pkg::TGT_EARTH: begin
                            if (!earth_fitted_reg) begin
                                status_next = sbi_pkg::ST_ABSENT;
                            end else if (cl && (state_reg.breaker_pos || state_reg.bus_a_pos ||
                                         state_reg.bus_b_pos ||
                                         (line_fitted_reg && state_reg.line_ds_pos))) begin
                                status_next = sbi_pkg::ST_BLOCKED;
                            end else begin
                                state_next.earth_pos = cl;
                            end
                        end
                        default: begin
                            status_next = sbi_pkg::ST_ABSENT;
                        end
                    endcase
                end
            end
            sbi_pkg::FUNC_TRIP_SET: begin
                state_next.trip_lockout = 1'b1;
                state_next.breaker_pos  = 1'b0;
            end
            sbi_pkg::FUNC_TRIP_CLR: begin
                state_next.trip_lockout = 1'b0;
            end
            sbi_pkg::FUNC_CPLR_SET: begin
                state_next.cplr_rdy = 1'b1;
            end
            sbi_pkg::FUNC_CPLR_CLR: begin
                state_next.cplr_rdy = 1'b0;
            end
            default: begin
                state_next = state_reg;
            end
        endcase
    end

    always_comb begin
        result_next.status          = status_next;
        result_next.breaker_closed  = state_next.breaker_pos;
        result_next.bus_a_closed    = state_next.bus_a_pos;
        result_next.bus_b_closed    = state_next.bus_b_pos;
        result_next.line_ds_closed  = state_next.line_ds_pos;
        result_next.earth_closed    = state_next.earth_pos;
        result_next.coupling_closed = state_next.breaker_pos && state_next.bus_a_pos &&
                                      state_next.bus_b_pos;
        result_next.lockout_active  = state_next.trip_lockout;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg         <= 1'b0;
            out_vld_reg        <= 1'b0;
            state_reg          <= sbi_pkg::BAY_STATE_RESET;
            bay_is_coupler_reg <= 1'b0;
            line_fitted_reg    <= 1'b1;
            earth_fitted_reg   <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
                state_reg   <= state_next;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    sbi_pkg::CFG_BAY_IS_COUPLER: bay_is_coupler_reg <= cfg_data;
                    sbi_pkg::CFG_LINE_DS_FITTED: line_fitted_reg    <= cfg_data;
                    sbi_pkg::CFG_EARTH_FITTED:   earth_fitted_reg   <= cfg_data;
                    default: begin
                        bay_is_coupler_reg <= bay_is_coupler_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_word;
        end
        if (advance) begin
            out_word_reg <= result_next;
        end
    end

    // The breaker and the earth switch are never closed together.
    a_no_breaker_on_earth: assert property (@(posedge aclk) disable iff (!aresetn)
        !(state_reg.breaker_pos && state_reg.earth_pos))
        else $error("breaker and earth switch both closed");

    // An open breaker under lockout stays open.
    a_lockout_holds_open: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.trip_lockout && !state_reg.breaker_pos |=> !state_reg.breaker_pos)
        else $error("breaker closed under trip lockout");

    // A test operation leaves every position untouched.
    a_test_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_word_reg.func == sbi_pkg::FUNC_OPERATE && in_word_reg.test_request
        |=> $stable(state_reg))
        else $error("test operation changed state");

    // A held input word is not lost while the result side stalls.
    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !advance |=> in_vld_reg && $stable(in_word_reg))
        else $error("input word dropped while stalled");

endmodule
